@@ hdl/mcpq_pkg.sv @@
package mcpq_pkg;

  localparam int CHANNELS = 4;
  localparam int SAMPLE_BITS = 4;
  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;
  localparam logic [CNT_W-1:0] CONFIRM_RESET = 8'd5;
  localparam logic [CNT_W-1:0] LOCKOUT_RESET = 8'd20;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_CONFIRM_SAMPLES = 1'b0,
    REG_LOCKOUT_TICKS   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic       opcode;
    logic [3:0] pin_samples;
    logic [1:0] channel;
  } req_t;

  typedef struct packed {
    logic [3:0] pending_flags;
    logic       read_value;
  } rsp_t;

  typedef struct packed {
    logic tick;
    logic level;
    logic clear;
  } lane_ctl_t;

  typedef struct packed {
    logic pending;
    logic pending_next;
  } lane_status_t;

endpackage

@@ hdl/mcpq_lane.sv @@
module mcpq_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [mcpq_pkg::CNT_W-1:0]        confirm_samples,
  input  logic [mcpq_pkg::CNT_W-1:0]        lockout_ticks,
  input  mcpq_pkg::lane_ctl_t               ctl,
  output mcpq_pkg::lane_status_t            status
);

  logic [mcpq_pkg::CNT_W-1:0] lockout_count, lockout_count_next;
  logic [mcpq_pkg::CNT_W-1:0] confirm_count, confirm_count_next;
  logic [mcpq_pkg::CNT_W-1:0] count_inc;
  logic                       armed, armed_next;
  logic                       pending, pending_next;

  always_comb begin
    lockout_count_next = lockout_count;
    confirm_count_next = confirm_count;
    armed_next         = armed;
    pending_next       = pending;
    count_inc = (confirm_count < mcpq_pkg::COUNT_MAX) ? confirm_count + 1'b1 : confirm_count;
    if (ctl.tick) begin
      if (lockout_count != '0) begin
        lockout_count_next = lockout_count - 1'b1;
      end else if (!ctl.level) begin
        if (count_inc >= confirm_samples && armed) begin
          pending_next       = 1'b1;
          lockout_count_next = lockout_ticks;
          confirm_count_next = '0;
          armed_next         = 1'b0;
        end else begin
          confirm_count_next = count_inc;
        end
      end else begin
        confirm_count_next = '0;
        armed_next         = 1'b1;
      end
    end
    if (ctl.clear) begin
      pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_count <= '0;
      confirm_count <= '0;
      armed         <= 1'b1;
      pending       <= 1'b0;
    end else begin
      lockout_count <= lockout_count_next;
      confirm_count <= confirm_count_next;
      armed         <= armed_next;
      pending       <= pending_next;
    end
  end

  assign status.pending      = pending;
  assign status.pending_next = pending_next;

endmodule

@@ hdl/mcpq_merge.sv @@
module mcpq_merge (
  input  mcpq_pkg::req_t         req,
  input  mcpq_pkg::lane_status_t status [mcpq_pkg::CHANNELS],
  output mcpq_pkg::rsp_t         rsp
);

  logic [3:0] cur;
  logic [3:0] nxt;

  always_comb begin
    cur = '0;
    nxt = '0;
    for (int c = 0; c < mcpq_pkg::CHANNELS && c < 4; c++) begin
      cur[c] = status[c].pending;
      nxt[c] = status[c].pending_next;
    end
    rsp.pending_flags = nxt;
    rsp.read_value    = (req.opcode == mcpq_pkg::OP_READ) ? cur[req.channel] : 1'b0;
  end

endmodule

@@ hdl/multi_channel_presence_qualifier_core.sv @@
// Multi-channel presence qualifier: per-channel counting debouncer with lockout.
// Request channel (req_valid/req_ready/req) carries either a tick with one
// active-low sample bit per channel, or a read that returns and clears one
// channel's sticky event flag. Every request produces exactly one response
// (rsp_valid/rsp_ready/rsp) with the pending flags after the request and,
// for reads, the flag value before clearing. The response is registered.
// Throughput: one request per cycle while req_ready is high; each channel has
// its own lane of counters, so all channels update in the same cycle and a
// merge stage forms the response.
// A two-entry output (register plus skid) keeps req_ready high while one
// response waits; req_ready drops only when both entries are full, i.e. the
// receiver has stalled for two responses.
// Reset (rst, synchronous): counters zero, channels armed, flags clear,
// thresholds back to 5 confirm samples and 20 lockout ticks, output empty.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once; they must
// be made only while no request is in flight, which the block does not enforce.
module multi_channel_presence_qualifier_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [mcpq_pkg::CNT_W-1:0] cfg_data,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  mcpq_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output mcpq_pkg::rsp_t             rsp
);

  logic [mcpq_pkg::CNT_W-1:0] confirm_samples;
  logic [mcpq_pkg::CNT_W-1:0] lockout_ticks;
  logic                       accept;
  mcpq_pkg::lane_status_t     status [mcpq_pkg::CHANNELS];
  mcpq_pkg::rsp_t             result;
  mcpq_pkg::rsp_t             skid;
  logic                       skid_valid;

  assign req_ready = !skid_valid;
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_samples <= mcpq_pkg::CONFIRM_RESET;
      lockout_ticks   <= mcpq_pkg::LOCKOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mcpq_pkg::REG_CONFIRM_SAMPLES: confirm_samples <= cfg_data;
        mcpq_pkg::REG_LOCKOUT_TICKS:   lockout_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar c = 0; c < mcpq_pkg::CHANNELS; c++) begin : g_lane
    mcpq_pkg::lane_ctl_t ctl;
    always_comb begin
      ctl.tick  = accept && (req.opcode == mcpq_pkg::OP_TICK);
      ctl.level = (c < mcpq_pkg::SAMPLE_BITS) ? req.pin_samples[c % mcpq_pkg::SAMPLE_BITS]
                                               : 1'b0;
      ctl.clear = accept && (req.opcode == mcpq_pkg::OP_READ) && (32'(req.channel) == c);
    end
    mcpq_lane u_lane (
      .clk             (clk),
      .rst             (rst),
      .confirm_samples (confirm_samples),
      .lockout_ticks   (lockout_ticks),
      .ctl             (ctl),
      .status          (status[c])
    );
  end

  mcpq_merge u_merge (
    .req    (req),
    .status (status),
    .rsp    (result)
  );

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || rsp_ready) begin
      rsp_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || rsp_ready) begin
      rsp <= skid_valid ? skid : result;
    end else if (accept) begin
      skid <= result;
    end
  end

endmodule

@@ tb/multi_channel_presence_qualifier_core_tb.sv @@
`timescale 1ns / 100ps

module multi_channel_presence_qualifier_core_tb;

  localparam int IDLE_LIMIT = 1000;

  class qualifier_scoreboard;
    logic [mcpq_pkg::CNT_W-1:0] confirm_threshold;
    logic [mcpq_pkg::CNT_W-1:0] lockout_load;
    logic [mcpq_pkg::CNT_W-1:0] hold_off [mcpq_pkg::CHANNELS];
    logic [mcpq_pkg::CNT_W-1:0] low_run [mcpq_pkg::CHANNELS];
    bit armed [mcpq_pkg::CHANNELS];
    bit flagged [mcpq_pkg::CHANNELS];
    mcpq_pkg::rsp_t awaited_status [$];
    int errors;
    int requests;
    int reads;
    int responses;
    int detections;
    int events_read;

    function new();
      confirm_threshold = mcpq_pkg::CONFIRM_RESET;
      lockout_load = mcpq_pkg::LOCKOUT_RESET;
      for (int c = 0; c < mcpq_pkg::CHANNELS; c++) begin
        hold_off[c] = '0;
        low_run[c] = '0;
        armed[c] = 1'b1;
        flagged[c] = 1'b0;
      end
      errors = 0;
      requests = 0;
      reads = 0;
      responses = 0;
      detections = 0;
      events_read = 0;
    endfunction

    function void set_register(mcpq_pkg::reg_index_t idx,
                               logic [mcpq_pkg::CNT_W-1:0] value);
      case (idx)
        mcpq_pkg::REG_CONFIRM_SAMPLES: confirm_threshold = value;
        mcpq_pkg::REG_LOCKOUT_TICKS: lockout_load = value;
        default: ;
      endcase
    endfunction

    function int outstanding();
      return awaited_status.size();
    endfunction

    function void advance_channel(int c, logic level);
      if (hold_off[c] != 0) begin
        hold_off[c]--;
      end else if (!level) begin
        if (low_run[c] != mcpq_pkg::COUNT_MAX) low_run[c]++;
        if (low_run[c] >= confirm_threshold && armed[c]) begin
          flagged[c] = 1'b1;
          hold_off[c] = lockout_load;
          low_run[c] = '0;
          armed[c] = 1'b0;
          detections++;
        end
      end else begin
        low_run[c] = '0;
        armed[c] = 1'b1;
      end
    endfunction

    function void predict_request(mcpq_pkg::req_t r);
      mcpq_pkg::rsp_t status;
      status.read_value = 1'b0;
      requests++;
      if (r.opcode == mcpq_pkg::OP_TICK) begin
        for (int c = 0; c < mcpq_pkg::CHANNELS; c++) advance_channel(c, r.pin_samples[c]);
      end else begin
        reads++;
        if (r.channel < mcpq_pkg::CHANNELS) begin
          status.read_value = flagged[r.channel];
          if (flagged[r.channel]) events_read++;
          flagged[r.channel] = 1'b0;
        end
      end
      status.pending_flags = '0;
      for (int c = 0; c < mcpq_pkg::CHANNELS; c++) status.pending_flags[c] = flagged[c];
      awaited_status.push_back(status);
    endfunction

    function void check_status(mcpq_pkg::rsp_t actual);
      mcpq_pkg::rsp_t status;
      responses++;
      if (awaited_status.size() == 0) begin
        $error("unexpected response: pending_flags %h read_value %b",
               actual.pending_flags, actual.read_value);
        errors++;
      end else begin
        status = awaited_status.pop_front();
        if (actual.pending_flags !== status.pending_flags) begin
          $error("pending_flags: expected %h, got %h", status.pending_flags,
                 actual.pending_flags);
          errors++;
        end
        if (actual.read_value !== status.read_value) begin
          $error("read_value: expected %b, got %b", status.read_value, actual.read_value);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [mcpq_pkg::CNT_W-1:0] cfg_data;
  logic req_valid;
  logic req_ready;
  mcpq_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  mcpq_pkg::rsp_t rsp;

  qualifier_scoreboard board;
  bit steady;
  int settings_used;

  multi_channel_presence_qualifier_core u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) board.check_status(rsp);
      rsp_ready <= steady || ($urandom_range(99) >= 10);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_request(input mcpq_pkg::req_t r);
    if (!steady && $urandom_range(99) < 10) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    board.predict_request(r);
  endtask

  task automatic tick(input logic [3:0] samples);
    mcpq_pkg::req_t r;
    r.opcode = mcpq_pkg::OP_TICK;
    r.pin_samples = samples;
    r.channel = 2'($urandom_range(3));
    send_request(r);
  endtask

  task automatic read_flag(input logic [1:0] ch);
    mcpq_pkg::req_t r;
    r.opcode = mcpq_pkg::OP_READ;
    r.pin_samples = 4'($urandom_range(15));
    r.channel = ch;
    send_request(r);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_register(input mcpq_pkg::reg_index_t idx,
                                input logic [mcpq_pkg::CNT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    board.set_register(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input int confirm, input int lockout);
    drain();
    write_register(mcpq_pkg::REG_CONFIRM_SAMPLES, mcpq_pkg::CNT_W'(confirm));
    write_register(mcpq_pkg::REG_LOCKOUT_TICKS, mcpq_pkg::CNT_W'(lockout));
    settings_used++;
  endtask

  // hold a sample pattern for a random run, mixing in reads and stray bit flips
  task automatic run_traffic(input int count, input int run_max);
    logic [3:0] pattern;
    logic [3:0] samples;
    int run_left;
    run_left = 0;
    pattern = 4'hF;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 20) begin
        read_flag(2'($urandom_range(3)));
      end else begin
        if (run_left == 0) begin
          pattern = 4'($urandom_range(15));
          run_left = $urandom_range(run_max, 1);
        end
        run_left--;
        samples = pattern;
        if ($urandom_range(99) < 5) samples[2'($urandom_range(3))] ^= 1'b1;
        tick(samples);
      end
    end
  endtask

  initial begin
    board = new();
    steady = 1'b0;
    settings_used = 1;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = mcpq_pkg::REG_CONFIRM_SAMPLES;
    cfg_data = '0;
    req_valid = 1'b0;
    req = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ch = 0; ch < mcpq_pkg::CHANNELS; ch++) read_flag(2'(ch));
    tick(4'hF);
    repeat (5) tick(4'h0);
    tick(4'h0);
    read_flag(2'd0);
    read_flag(2'd0);
    read_flag(2'd3);
    run_traffic(200, 12);

    set_thresholds(1, 0);
    tick(4'hF);
    tick(4'h0);
    tick(4'h0);
    tick(4'h5);
    read_flag(2'd1);
    run_traffic(200, 4);

    set_thresholds(0, 0);
    tick(4'hF);
    tick(4'h0);
    tick(4'h0);
    read_flag(2'd2);
    run_traffic(150, 3);

    // long low stretch: confirm at the top threshold, then saturate the counters
    set_thresholds(255, 0);
    steady = 1'b1;
    tick(4'hF);
    for (int i = 0; i < 520; i++) begin
      if ($urandom_range(9) == 0) read_flag(2'($urandom_range(3)));
      tick(4'h0);
    end
    steady = 1'b0;

    set_thresholds(3, 255);
    tick(4'hF);
    run_traffic(200, 8);

    set_thresholds(2, 1);
    run_traffic(100, 5);
    drain();
    run_traffic(100, 5);

    repeat (2) begin
      set_thresholds($urandom_range(12, 1), $urandom_range(30));
      run_traffic(100, board.confirm_threshold + 4);
    end

    drain();
    repeat (4) @(posedge clk);
    $display("covered %0d requests (%0d reads) and %0d responses over %0d threshold settings",
             board.requests, board.reads, board.responses, settings_used);
    $display("%0d detections predicted, %0d events returned by reads",
             board.detections, board.events_read);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
